/* rtl/ssr_pkg.sv */
// Package for the streaming substring replace block.
// Holds the request and result types, the register map and shared helpers.
// No dependencies.
package ssr_pkg;

    localparam int MAX_NEEDLE_DEF = 8;
    localparam int INDEX_BITS_DEF = 16;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 64;

    typedef enum logic [1:0] {
        REG_NEEDLE = 2'd0,
        REG_NLEN   = 2'd1,
        REG_REPL   = 2'd2,
        REG_MODE   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        found;
        logic [15:0] match_index;
    } t_out;

    typedef struct packed {
        logic [63:0] needle_bytes;
        logic [3:0]  needle_length;
        logic [63:0] replacement_bytes;
        logic        replace_mode;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic last;
        logic found;
    } t_burst_ctl;

    function automatic logic [7:0] char_at(input logic [63:0] packed_chars,
                                           input logic [2:0] k);
        char_at = packed_chars[{k, 3'b000} +: 8];
    endfunction

endpackage

/* rtl/ssr_regs.sv */
// Configuration register file with an APB-style access port.
// Depends on ssr_pkg for the register map and the configuration struct.
module ssr_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssr_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [ssr_pkg::DATA_BITS-1:0]   pwdata,
    output logic [ssr_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    output ssr_pkg::t_cfg                   o_cfg
);
    import ssr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.needle_bytes      <= '0;
            r_cfg.needle_length     <= 4'd1;
            r_cfg.replacement_bytes <= '0;
            r_cfg.replace_mode      <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEEDLE: r_cfg.needle_bytes      <= pwdata;
                REG_NLEN:   r_cfg.needle_length     <= pwdata[3:0];
                REG_REPL:   r_cfg.replacement_bytes <= pwdata;
                REG_MODE:   r_cfg.replace_mode      <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEEDLE: prdata = r_cfg.needle_bytes;
            REG_NLEN:   prdata = {60'd0, r_cfg.needle_length};
            REG_REPL:   prdata = r_cfg.replacement_bytes;
            REG_MODE:   prdata = {63'd0, r_cfg.replace_mode};
        endcase
    end

endmodule

/* rtl/ssr_core.sv */
// Input register and match window: compares, replaces and releases bytes.
// Depends on ssr_pkg; feeds ssr_burst with the bytes that leave each step.
module ssr_core #(
    parameter  int MAX_NEEDLE = ssr_pkg::MAX_NEEDLE_DEF,
    parameter  int INDEX_BITS = ssr_pkg::INDEX_BITS_DEF,
    localparam int LW         = $clog2(MAX_NEEDLE + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ssr_pkg::t_in                  i_in,
    input  ssr_pkg::t_cfg                 i_cfg,
    input  logic                          i_can_load,
    output ssr_pkg::t_burst_ctl           o_ctl,
    output logic [MAX_NEEDLE-1:0][7:0]    o_bytes,
    output logic [LW-1:0]                 o_count,
    output logic [INDEX_BITS-1:0]         o_index
);
    import ssr_pkg::*;

    localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    logic                       r_in_valid;
    t_in                        r_in;
    logic [MAX_NEEDLE-1:0][7:0] r_win;
    logic [LW-1:0]              r_fill;
    logic [INDEX_BITS-1:0]      r_pos;
    logic [LW-1:0]              r_blk;
    logic                       r_any;
    logic [INDEX_BITS-1:0]      r_idx;

    logic [MAX_NEEDLE-1:0][7:0] n_win;
    logic [LW-1:0]              n_fill;
    logic [INDEX_BITS-1:0]      n_pos;
    logic [LW-1:0]              n_blk;
    logic                       n_any;
    logic [INDEX_BITS-1:0]      n_idx;

    logic [LW-1:0]              eff_len;
    logic [LW-1:0]              fill1;
    logic [LW-1:0]              start_off;
    logic [LW-1:0]              drop;
    logic                       full;
    logic                       try_match;
    logic                       do_hit;
    logic [MAX_NEEDLE-1:0]      in_rng;
    logic [MAX_NEEDLE-1:0]      eq;
    logic [MAX_NEEDLE-1:0][7:0] w1;
    logic [MAX_NEEDLE-1:0][7:0] w2;
    logic [INDEX_BITS-1:0]      hit_start;
    logic [INDEX_BITS-1:0]      idx_upd;
    logic [LW-1:0]              count;
    logic                       advance;

    always_comb begin
        logic [LW-1:0] k;
        logic [LW:0]   sh;
        k  = '0;
        sh = '0;
        if (i_cfg.needle_length == 4'd0) begin
            eff_len = LW'(1);
        end else if (i_cfg.needle_length > 4'(MAX_NEEDLE)) begin
            eff_len = LW'(MAX_NEEDLE);
        end else begin
            eff_len = LW'(i_cfg.needle_length);
        end
        fill1     = r_fill + LW'(1);
        full      = fill1 >= eff_len;
        start_off = fill1 - eff_len;
        drop      = start_off + LW'(1);
        try_match = (r_blk == '0) && full && (i_cfg.replace_mode || !r_any);
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            w1[j]     = (LW'(j) == r_fill) ? r_in.in_byte : r_win[j];
            in_rng[j] = (LW'(j) >= start_off) && (LW'(j) < fill1);
            k         = LW'(j) - start_off;
            eq[j]     = !in_rng[j] || (w1[j] == char_at(i_cfg.needle_bytes, 3'(k)));
        end
        do_hit = try_match && (&eq);
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            k     = LW'(j) - start_off;
            w2[j] = (do_hit && in_rng[j]) ?
                    char_at(i_cfg.replacement_bytes, 3'(k)) : w1[j];
        end

        if (&r_pos) begin
            hit_start = r_pos;
        end else if (r_pos >= INDEX_BITS'(eff_len - LW'(1))) begin
            hit_start = r_pos - INDEX_BITS'(eff_len - LW'(1));
        end else begin
            hit_start = '0;
        end
        idx_upd = do_hit ? hit_start : r_idx;

        if (r_in.last_byte) begin
            count = fill1;
        end else if (full) begin
            count = drop;
        end else begin
            count = '0;
        end

        n_pos = (&r_pos) ? r_pos : r_pos + INDEX_BITS'(1);
        n_any = r_any || do_hit;
        n_idx = idx_upd;
        if (r_blk != '0) begin
            n_blk = r_blk - LW'(1);
        end else if (do_hit) begin
            n_blk = eff_len - LW'(1);
        end else begin
            n_blk = r_blk;
        end
        if (full) begin
            n_fill = eff_len - LW'(1);
            for (int j = 0; j < MAX_NEEDLE; j++) begin
                sh       = (LW + 1)'(j) + (LW + 1)'(drop);
                n_win[j] = (sh < (LW + 1)'(MAX_NEEDLE)) ? w2[IW'(sh)] : 8'h00;
            end
        end else begin
            n_fill = fill1;
            n_win  = w2;
        end
        if (r_in.last_byte) begin
            n_fill = '0;
            n_pos  = '0;
            n_blk  = '0;
            n_any  = 1'b0;
            n_idx  = '0;
        end
    end

    assign advance     = r_in_valid && ((count == '0) || i_can_load);
    assign o_ready     = !r_in_valid || advance;
    assign o_ctl.load  = advance && (count != '0);
    assign o_ctl.last  = r_in.last_byte;
    assign o_ctl.found = r_any || do_hit;
    assign o_bytes     = w2;
    assign o_count     = count;
    assign o_index     = idx_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fill     <= '0;
            r_pos      <= '0;
            r_blk      <= '0;
            r_any      <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_fill <= n_fill;
                r_pos  <= n_pos;
                r_blk  <= n_blk;
                r_any  <= n_any;
                r_idx  <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_win <= n_win;
        end
    end

`ifndef ASSERT_OFF
    a_fill_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < LW'(MAX_NEEDLE))
        else $error("window fill reached the window depth");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_byte |=> (r_fill == '0) && !r_any && (r_pos == '0))
        else $error("stream state not cleared after the final byte");

    a_block_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blk != '0) |-> r_any)
        else $error("window blocked without any replacement");
`endif

endmodule

/* rtl/ssr_burst.sv */
// Result buffer that holds the bytes released by one step and hands them out one at a time.
// Depends on ssr_pkg for the result type and the load control struct.
module ssr_burst #(
    parameter  int MAX_NEEDLE = ssr_pkg::MAX_NEEDLE_DEF,
    parameter  int INDEX_BITS = ssr_pkg::INDEX_BITS_DEF,
    localparam int LW         = $clog2(MAX_NEEDLE + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssr_pkg::t_burst_ctl           i_ctl,
    input  logic [MAX_NEEDLE-1:0][7:0]    i_bytes,
    input  logic [LW-1:0]                 i_count,
    input  logic [INDEX_BITS-1:0]         i_index,
    output logic                          o_can_load,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ssr_pkg::t_out                 o_out
);
    import ssr_pkg::*;

    logic [MAX_NEEDLE-1:0][7:0] r_buf;
    logic [LW-1:0]              r_cnt;
    logic                       r_last;
    logic                       r_found;
    logic [INDEX_BITS-1:0]      r_idx;
    logic                       pop;
    logic                       fin;

    assign pop        = (r_cnt != '0) && i_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == LW'(1)) && i_ready);
    assign o_valid    = r_cnt != '0;
    assign fin        = r_last && (r_cnt == LW'(1));

    assign o_out.out_byte    = r_buf[0];
    assign o_out.out_last    = fin;
    assign o_out.found       = fin && r_found;
    assign o_out.match_index = fin ? 16'(r_idx) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= i_count;
        end else if (pop) begin
            r_cnt <= r_cnt - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_buf   <= i_bytes;
            r_last  <= i_ctl.last;
            r_found <= i_ctl.found;
            r_idx   <= i_index;
        end else if (pop) begin
            for (int j = 0; j < MAX_NEEDLE; j++) begin
                r_buf[j] <= (j + 1 < MAX_NEEDLE) ? r_buf[(j + 1) % MAX_NEEDLE] : 8'h00;
            end
        end
    end

`ifndef ASSERT_OFF
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> (r_cnt == '0) || ((r_cnt == LW'(1)) && i_ready))
        else $error("burst loaded over bytes not yet delivered");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_ctl.load |=> r_cnt == $past(r_cnt) - LW'(1))
        else $error("burst count did not follow a delivered byte");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LW'(MAX_NEEDLE))
        else $error("burst count beyond the buffer depth");
`endif

endmodule

/* rtl/stream_substring_replace.sv */
// Streaming substring search and replace, top level.
// Instantiates ssr_regs, ssr_core and ssr_burst; types come from ssr_pkg.
//
// Usage: write the needle, its length, the replacement and the mode over the
// APB port while the stream is idle. Characters arrive one per request on the
// input channel, the final one flagged by last_byte. Result requests carry one
// character each; the final one of a string has out_last set together with
// found and match_index.
// A character leaves once a full window of needle length stands behind it,
// so a request normally yields one result, none while the window fills, and
// the whole window on the final character.
// Throughput is one request per cycle while at most one character leaves per
// request and the receiver takes every result. The final request releases the
// whole window at one character per cycle while the receiver is ready, so the
// next request that releases characters waits until the result buffer holds one.
// An accepted request passes the input register and then the result buffer
// before its first result appears.
// When the receiver stalls, the result buffer holds and the input register
// takes one more request before input ready drops.
// Reset clears the registers to their defaults and empties the window.
module stream_substring_replace #(
    parameter int MAX_NEEDLE = ssr_pkg::MAX_NEEDLE_DEF,
    parameter int INDEX_BITS = ssr_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ssr_pkg::t_in                    i_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ssr_pkg::t_out                   o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssr_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [ssr_pkg::DATA_BITS-1:0]   pwdata,
    output logic [ssr_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready
);
    import ssr_pkg::*;

    localparam int LW = $clog2(MAX_NEEDLE + 1);

    t_cfg                       cfg;
    t_burst_ctl                 burst_ctl;
    logic [MAX_NEEDLE-1:0][7:0] burst_bytes;
    logic [LW-1:0]              burst_count;
    logic [INDEX_BITS-1:0]      burst_index;
    logic                       can_load;

    ssr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssr_core #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_can_load (can_load),
        .o_ctl      (burst_ctl),
        .o_bytes    (burst_bytes),
        .o_count    (burst_count),
        .o_index    (burst_index)
    );

    ssr_burst #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .INDEX_BITS (INDEX_BITS)
    ) u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (burst_ctl),
        .i_bytes    (burst_bytes),
        .i_count    (burst_count),
        .i_index    (burst_index),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

endmodule

/* bench/stream_substring_replace_test.sv */
// Self-checking testbench for stream_substring_replace: a scoreboard class predicts
// every outgoing character from the accepted requests and the register values.
// Depends on ssr_pkg and the stream_substring_replace RTL.
`timescale 1ns / 1ps

class replace_scoreboard;
    localparam int unsigned WINDOW_MAX = ssr_pkg::MAX_NEEDLE_DEF;
    localparam int unsigned INDEX_MAX  = (1 << ssr_pkg::INDEX_BITS_DEF) - 1;

    logic [63:0]   needle;
    logic [3:0]    nlen;
    logic [63:0]   repl;
    logic          mode;

    logic [7:0]    win [WINDOW_MAX];
    int unsigned   fill;
    int unsigned   pos;
    int unsigned   blocked;
    logic          any_found;
    logic [15:0]   reported;

    ssr_pkg::t_out due_chars [$];
    int unsigned   errors;

    function new();
        needle = '0;
        nlen   = 4'd1;
        repl   = '0;
        mode   = 1'b0;
        errors = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (win[i]) win[i] = 8'd0;
        fill      = 0;
        pos       = 0;
        blocked   = 0;
        any_found = 1'b0;
        reported  = 16'd0;
    endfunction

    function void set_reg(ssr_pkg::t_reg_idx idx, logic [63:0] val);
        case (idx)
            ssr_pkg::REG_NEEDLE: needle = val;
            ssr_pkg::REG_NLEN:   nlen   = val[3:0];
            ssr_pkg::REG_REPL:   repl   = val;
            ssr_pkg::REG_MODE:   mode   = val[0];
            default: ;
        endcase
    endfunction

    function int unsigned active_len();
        if (nlen == 4'd0) return 1;
        if (nlen > WINDOW_MAX) return WINDOW_MAX;
        return nlen;
    endfunction

    function void push_char(logic [7:0] b, logic lst);
        ssr_pkg::t_out c;
        c.out_byte    = b;
        c.out_last    = lst;
        c.found       = lst & any_found;
        c.match_index = lst ? reported : 16'd0;
        due_chars.push_back(c);
    endfunction

    function void note_request(ssr_pkg::t_in req);
        int unsigned len;
        int unsigned here;
        int unsigned s;
        int unsigned drop;
        int unsigned k;
        logic        hit;
        len  = active_len();
        here = pos;
        if (fill < WINDOW_MAX) begin
            win[fill] = req.in_byte;
            fill++;
        end
        if (pos < INDEX_MAX) pos++;
        if (blocked > 0) begin
            blocked--;
        end else if (fill >= len && (mode || !any_found)) begin
            s   = fill - len;
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
                if (win[s + k] != needle[8 * k +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (k = 0; k < len; k++) win[s + k] = repl[8 * k +: 8];
                if (here >= INDEX_MAX) reported = 16'(INDEX_MAX);
                else if (here >= len - 1) reported = 16'(here - (len - 1));
                else reported = 16'd0;
                any_found = 1'b1;
                blocked   = len - 1;
            end
        end
        if (req.last_byte) begin
            for (k = 0; k < fill; k++) push_char(win[k], k + 1 == fill);
            clear_stream();
        end else if (fill >= len) begin
            drop = fill - len + 1;
            for (k = 0; k < drop; k++) push_char(win[k], 1'b0);
            for (k = 0; k < fill - drop; k++) win[k] = win[k + drop];
            fill = fill - drop;
            for (k = fill; k < WINDOW_MAX; k++) win[k] = 8'd0;
        end
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(ssr_pkg::t_out got);
        ssr_pkg::t_out want;
        if (due_chars.size() == 0) begin
            flag($sformatf("unexpected character: byte %h last %b found %b index %0d",
                           got.out_byte, got.out_last, got.found, got.match_index));
        end else begin
            want = due_chars.pop_front();
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                    got.found !== want.found || got.match_index !== want.match_index) begin
                flag($sformatf({"wrong character: expected byte %h last %b found %b ",
                                "index %0d, got byte %h last %b found %b index %0d"},
                               want.out_byte, want.out_last, want.found, want.match_index,
                               got.out_byte, got.out_last, got.found, got.match_index));
            end
        end
    endfunction

    function void close_out();
        if (due_chars.size() != 0)
            flag($sformatf("%0d expected characters never arrived", due_chars.size()));
    endfunction
endclass

module stream_substring_replace_test;
    import ssr_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in                  i_in;
    logic                 o_valid;
    logic                 i_ready;
    t_out                 o_out;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    replace_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int stall_cycles;

    stream_substring_replace dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_out);
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] b, input logic lst);
        t_in req;
        req.in_byte   = b;
        req.last_byte = lst;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_in    <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(req);
        items_sent++;
    endtask

    task automatic send_packed(input logic [63:0] chars, input int count, input logic close);
        for (int k = 0; k < count; k++) send_char(chars[8 * k +: 8], close && k == count - 1);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.due_chars.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [63:0] nb, input logic [3:0] nl,
                                input logic [63:0] rb, input logic md);
        logic [63:0] vals [4];
        t_reg_idx    idx;
        settle();
        vals[REG_NEEDLE] = nb;
        vals[REG_NLEN]   = {60'd0, nl};
        vals[REG_REPL]   = rb;
        vals[REG_MODE]   = {63'd0, md};
        for (int r = 0; r < 4; r++) begin
            idx = t_reg_idx'(r);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 3'b000};
            pwdata  <= vals[r];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            sb.set_reg(idx, vals[r]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_config();
        logic [3:0] nl;
        case ($urandom_range(9))
            0:       nl = 4'($urandom_range(15));
            1:       nl = 4'd8;
            default: nl = 4'($urandom_range(1, 4));
        endcase
        write_config({$urandom, $urandom}, nl, {$urandom, $urandom}, 1'($urandom_range(1)));
    endtask

    task automatic random_string(input int max_len);
        int          n;
        int          i;
        int          part;
        int unsigned len;
        logic [7:0]  b;
        n   = $urandom_range(1, max_len);
        len = sb.active_len();
        i   = 0;
        while (i < n) begin
            if ($urandom_range(9) < 3) begin
                part = ($urandom_range(3) == 0) ? $urandom_range(1, len) : len;
                for (int k = 0; k < part && i < n; k++) begin
                    send_char(sb.needle[8 * k +: 8], i == n - 1);
                    i++;
                end
            end else begin
                if ($urandom_range(1)) b = 8'($urandom_range(255));
                else b = sb.needle[8 * $urandom_range(len - 1) +: 8];
                send_char(b, i == n - 1);
                i++;
            end
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle, input int target);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        while (items_sent < target) begin
            if ($urandom_range(1)) random_config();
            random_string(20);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_in          <= '0;
        i_ready       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        stall_cycles  <= 0;
        items_sent    = 0;
        send_idle_pct = 32;
        recv_idle_pct = 60;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every occurrence replaced, then the first one only.
        write_config(64'h6261, 4'd2, 64'h5958, 1'b1);
        send_packed(64'h626162616261, 6, 1'b1);
        write_config(64'h6261, 4'd2, 64'h5958, 1'b0);
        send_packed(64'h6261626178, 5, 1'b1);
        // Length zero acts as one; zero bytes are ordinary characters.
        write_config(64'h0, 4'd0, 64'hFF, 1'b1);
        send_packed(64'h00FF00, 3, 1'b1);
        // Length above the maximum acts as the full window, all-ones needle.
        write_config({64{1'b1}}, 4'd15, 64'h0, 1'b0);
        send_packed({64{1'b1}}, 8, 1'b1);
        // Length and mode changed in the middle of a string.
        write_config(64'h64636261, 4'd4, 64'h5A5A5958, 1'b0);
        send_packed(64'h62617A, 3, 1'b0);
        write_config(64'h64636261, 4'd2, 64'h5A5A5958, 1'b1);
        send_packed(64'h6261, 2, 1'b1);

        run_phase(32, 60, 80);
        run_phase(60, 32, 145);
        run_phase(0, 0, 210);

        settle();
        sb.close_out();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
